// ===== design/binary_square_erosion_defines.svh =====
// Assertion macros shared by the binary erosion block.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef BINARY_SQUARE_EROSION_DEFINES_SVH
`define BINARY_SQUARE_EROSION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/bse_pkg.sv =====
// Shared constants and types of the binary square erosion block.
// Used by bse_out_fifo and binary_square_erosion; depends on nothing.
`default_nettype none

package bse_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 8;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int RAD_W     = 4;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = DIM_W + 1;
    localparam int LAG_W     = DIM_W + RAD_W;
    localparam int WIN_BITS  = 2 * MAX_RADIUS + 1;
    localparam int CFG_IDX_W = 2;

    localparam int OUT_DEPTH = 3;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [PIX_W-1:0] PIX_BLACK = '0;
    localparam logic [PIX_W-1:0] PIX_WHITE = '1;
    localparam logic             CMD_FLUSH = 1'b1;

    localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(5);
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/bse_out_fifo.sv =====
// Small output queue that decouples the erosion pipeline from the result stream.
// Depends on bse_pkg for its depth and item type.
`default_nettype none
`include "binary_square_erosion_defines.svh"

module bse_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  bse_pkg::t_out_item            i_item,
    input  logic                          i_ready,
    output logic                          o_valid,
    output bse_pkg::t_out_item            o_item,
    output logic [bse_pkg::CNT_W-1:0]     o_count
);
    import bse_pkg::*;

    t_out_item          r_slot [OUT_DEPTH];
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;
    logic [CNT_W-1:0]   n_count;
    logic               pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        next_ptr = (ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_head];
    assign o_count = r_count;
    assign pop     = o_valid & i_ready;

    always_comb begin
        n_head  = pop ? next_ptr(r_head) : r_head;
        n_tail  = i_push ? next_ptr(r_tail) : r_tail;
        case ({i_push, pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    `BSE_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !pop && (r_count == CNT_W'(OUT_DEPTH))), "output queue overflow")
    `BSE_ASSERT(a_empty_aligned, i_clk, i_rst_n, (r_count != '0) || (r_head == r_tail), "empty queue with pointers apart")

endmodule

`default_nettype wire

// ===== design/binary_square_erosion.sv =====
// Binary erosion with a square window over a raster pixel stream.
// A result passes through the second-stage registers and then the output queue before it leaves.
// Throughput: one item per cycle while the output queue has room, set by the column history RAM read and write-back.
// Results start radius*width+radius items into a frame; flush transfers drain the tail.
// Reset sets radius 5, width 640, height 480 and clears all positions; the RAM is not cleared.
`default_nettype none
`include "binary_square_erosion_defines.svh"

module binary_square_erosion (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bse_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel
    input  logic                              s_axis_tuser,   // [0] cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bse_pkg::PIX_W-1:0]         m_axis_tdata,   // [7:0] out_pixel
    output logic                              m_axis_tlast,   // frame_end
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bse_pkg::DIM_W-1:0]         i_cfg_data
);
    import bse_pkg::*;

    logic [RAD_W-1:0]    r_radius;
    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;

    logic [RAD_W-1:0]    eff_rad;
    logic [DIM_W-1:0]    eff_w;
    logic [DIM_W-1:0]    eff_h;
    logic [DIM_W-1:0]    eff_w_m1;
    logic [DIM_W-1:0]    eff_h_m1;
    logic [RAD_W:0]      two_rad;
    logic [LAG_W-1:0]    lag;

    logic [COL_W-1:0]    r_in_col;
    logic [ROW_W-1:0]    r_in_row;
    logic [COL_W-1:0]    r_out_col;
    logic [DIM_W-1:0]    r_out_row;
    logic [LAG_W-1:0]    r_wait;
    logic [COL_W-1:0]    n_in_col;
    logic [ROW_W-1:0]    n_in_row;
    logic [COL_W-1:0]    n_out_col;
    logic [DIM_W-1:0]    n_out_row;
    logic [LAG_W-1:0]    n_wait;

    t_cfg_index          cfg_idx;
    logic                cfg_hit;

    logic                s0_accept;
    logic                s0_in_frame;
    logic                s0_go;
    logic                s0_flag;
    logic                s0_fend;
    logic                at_lag;
    logic                in_col_wrap;
    logic                out_col_wrap;
    logic [WIN_BITS-1:0] s0_vmask;
    logic [WIN_BITS-1:0] s0_hmask;

    logic [WIN_BITS-1:0] r_hist_mem [MAX_WIDTH];
    logic [WIN_BITS-1:0] r_rd_data;
    logic [WIN_BITS-1:0] r_fwd_data;
    logic                r_fwd_hit;

    logic                r_s1_valid;
    logic                r_s1_out;
    logic                r_s1_fend;
    logic                r_s1_flag;
    logic [COL_W-1:0]    r_s1_col;
    logic [WIN_BITS-1:0] r_s1_vmask;
    logic [WIN_BITS-1:0] r_s1_hmask;
    logic [WIN_BITS-1:0] r_win;

    logic [WIN_BITS-1:0] hist_old;
    logic [WIN_BITS-1:0] hist_new;
    logic [WIN_BITS-1:0] win_new;
    logic                col_black;
    logic                s1_black;
    logic                push;
    t_out_item           push_item;
    t_out_item           out_item;
    logic [CNT_W-1:0]    fifo_count;
    logic [CNT_W:0]      pending;

    // Effective configuration after clamping.
    always_comb begin
        eff_rad = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_radius;
        if (r_frame_width == '0) begin
            eff_w = DIM_W'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        eff_h    = (r_frame_height == '0) ? DIM_W'(1) : r_frame_height;
        eff_w_m1 = eff_w - DIM_W'(1);
        eff_h_m1 = eff_h - DIM_W'(1);
        two_rad  = {eff_rad, 1'b0};
        lag      = LAG_W'(eff_rad) * LAG_W'(eff_w) + LAG_W'(eff_rad);
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_index'(i_cfg_index);

    always_comb begin
        case (cfg_idx)
            CFG_RADIUS, CFG_WIDTH, CFG_HEIGHT: cfg_hit = i_cfg_valid;
            default:                           cfg_hit = 1'b0;
        endcase
    end

    // Front stage: position tracking, RAM read and window masks.
    assign pending       = {1'b0, fifo_count} + (CNT_W + 1)'(r_s1_valid & r_s1_out);
    assign s_axis_tready = (int'(pending) < OUT_DEPTH);
    assign s0_accept     = s_axis_tvalid & s_axis_tready;
    assign s0_in_frame   = (r_in_row < ROW_W'(eff_h));
    assign s0_go         = s0_accept & ~(s0_in_frame & (s_axis_tuser == CMD_FLUSH));
    assign s0_flag       = s0_in_frame & (s_axis_tdata == PIX_BLACK);
    assign at_lag        = (r_wait == lag);
    assign in_col_wrap   = (DIM_W'(r_in_col) == eff_w_m1);
    assign out_col_wrap  = (DIM_W'(r_out_col) == eff_w_m1);
    assign s0_fend       = (r_out_row == eff_h_m1) && out_col_wrap;

    always_comb begin
        for (int k = 0; k < WIN_BITS; k++) begin
            s0_vmask[k] = (k <= int'(two_rad)) && (k <= int'(r_in_row));
            s0_hmask[k] = (k <= int'(two_rad))
                       && (k <= int'(r_out_col) + int'(eff_rad))
                       && (k + int'(eff_w_m1) >= int'(r_out_col) + int'(eff_rad));
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_wait    = r_wait;
        if (s0_go) begin
            if (in_col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (at_lag) begin
                if (s0_fend) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_wait    = '0;
                end else if (out_col_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + DIM_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end else begin
                n_wait = r_wait + LAG_W'(1);
            end
        end
        if (cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_wait    = '0;
        end
    end

    // Second stage: shift the column history, OR it vertically, then across the row.
    assign hist_old  = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign hist_new  = {hist_old[WIN_BITS-2:0], r_s1_flag};
    assign col_black = |(hist_new & r_s1_vmask);
    assign win_new   = {r_win[WIN_BITS-2:0], col_black};
    assign s1_black  = |(win_new & r_s1_hmask);
    assign push      = r_s1_valid & r_s1_out;

    always_comb begin
        push_item.pixel     = s1_black ? PIX_BLACK : PIX_WHITE;
        push_item.frame_end = r_s1_fend;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_hist_mem[r_s1_col] <= hist_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_go) begin
            r_rd_data <= r_hist_mem[r_in_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_go) begin
            r_s1_col   <= r_in_col;
            r_s1_flag  <= s0_flag;
            r_s1_vmask <= s0_vmask;
            r_s1_hmask <= s0_hmask;
            r_s1_fend  <= s0_fend;
            r_fwd_data <= hist_new;
        end
        if (r_s1_valid) begin
            r_win <= win_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= RST_RADIUS;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_wait         <= '0;
            r_s1_valid     <= 1'b0;
            r_s1_out       <= 1'b0;
            r_fwd_hit      <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_wait     <= n_wait;
            r_s1_valid <= s0_go;
            r_s1_out   <= s0_go & at_lag;
            r_fwd_hit  <= s0_go & r_s1_valid & (r_s1_col == r_in_col);
            if (i_cfg_valid) begin
                case (cfg_idx)
                    CFG_RADIUS: r_radius       <= i_cfg_data[RAD_W-1:0];
                    CFG_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_HEIGHT: r_frame_height <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    bse_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_item  (out_item),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = out_item.pixel;
    assign m_axis_tlast = out_item.frame_end;

    `BSE_ASSERT(a_wait_bound, i_clk, i_rst_n, r_wait <= lag, "startup count passed the window lag")
    `BSE_ASSERT(a_out_in_frame, i_clk, i_rst_n, (r_out_row < eff_h) && (DIM_W'(r_out_col) < eff_w), "output position outside the frame")
    `BSE_ASSERT_NEXT(a_frame_end_clears, i_clk, i_rst_n, s0_go && at_lag && s0_fend, (r_in_row == '0) && (r_in_col == '0) && (r_wait == '0), "positions not cleared after frame end")
    `BSE_ASSERT(a_fwd_with_item, i_clk, i_rst_n, !r_fwd_hit || r_s1_valid, "forwarding without an item in the second stage")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for binary_square_erosion: streams small raster frames,
// predicts every eroded pixel in step with the accepted input and compares each result.
// Depends on bse_pkg and the binary_square_erosion RTL only.
module testbench;
    import bse_pkg::*;

    localparam int HIST_BITS = 3 * MAX_RADIUS + 1;
    localparam int STALL_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic             last;
    } t_eroded;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata;   // [7:0] pixel
    logic                 s_axis_tuser;   // [0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [PIX_W-1:0]     m_axis_tdata;   // [7:0] out_pixel
    logic                 m_axis_tlast;   // frame_end
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    binary_square_erosion i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    bit [HIST_BITS-1:0] black_hist [MAX_WIDTH];
    bit [RAD_W-1:0]     cfg_radius = RST_RADIUS;
    bit [DIM_W-1:0]     cfg_width = RST_WIDTH;
    bit [DIM_W-1:0]     cfg_height = RST_HEIGHT;
    int                 rx_row, rx_col, tx_row, tx_col;
    t_eroded            eroded_q[$];
    t_eroded            head_px;

    int errors;
    int cycles;
    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_reqs;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic int eff_radius();
        return (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
    endfunction

    function automatic void clear_positions();
        rx_row = 0;
        rx_col = 0;
        tx_row = 0;
        tx_col = 0;
    endfunction

    // Takes one accepted item and queues the eroded pixel it releases, if any.
    function automatic void erode_take(input logic cmd, input logic [PIX_W-1:0] pix);
        int w, h, rad, total, lag, q, row, col;
        int lo, hi, x0, x1, x, last, k0, n;
        bit flag, black;
        longint unsigned hv, mask;
        t_eroded res;
        w = eff_width();
        h = eff_height();
        rad = eff_radius();
        total = w * h;
        lag = rad * w + rad;
        q = rx_row * w + rx_col;
        row = rx_row;
        col = rx_col;
        black = 1'b0;
        if (q < total) begin
            if (cmd == CMD_FLUSH) return;
            flag = (pix == PIX_BLACK);
        end else begin
            flag = 1'b0;
        end
        black_hist[col] = {black_hist[col][HIST_BITS-2:0], flag};
        rx_col++;
        if (rx_col >= w) begin
            rx_col = 0;
            rx_row++;
        end
        if (q < lag) return;
        lo = (tx_row - rad < 0) ? 0 : tx_row - rad;
        hi = (tx_row + rad > h - 1) ? h - 1 : tx_row + rad;
        x0 = (tx_col - rad < 0) ? 0 : tx_col - rad;
        x1 = (tx_col + rad > w - 1) ? w - 1 : tx_col + rad;
        for (x = x0; x <= x1 && !black; x++) begin
            last = (x <= col) ? row : row - 1;
            k0 = last - hi;
            n = hi - lo + 1;
            if (k0 < 0 || k0 + n > 64 || n <= 0 || n >= 64) continue;
            hv = 64'(black_hist[x]);
            mask = (64'd1 << n) - 64'd1;
            if (((hv >> k0) & mask) != 0) black = 1'b1;
        end
        res.px = black ? PIX_BLACK : PIX_WHITE;
        res.last = 1'b0;
        if (tx_row * w + tx_col == total - 1) begin
            res.last = 1'b1;
            clear_positions();
        end else begin
            tx_col++;
            if (tx_col >= w) begin
                tx_col = 0;
                tx_row++;
            end
        end
        eroded_q.push_back(res);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(input int black_pct);
        if ($urandom_range(99) < black_pct) return PIX_BLACK;
        return PIX_W'($urandom_range(1, 255));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (eroded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual pixel %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                head_px = eroded_q.pop_front();
                if (m_axis_tdata !== head_px.px) begin
                    errors++;
                    $display("%0t: out_pixel mismatch, expected %0d, actual %0d",
                             $time, head_px.px, m_axis_tdata);
                end
                if (m_axis_tlast !== head_px.last) begin
                    errors++;
                    $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                             $time, head_px.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin : receiver
        int stall_left;
        int stalls_seen;
        stall_left = 0;
        stalls_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_reqs != stalls_seen) begin
                stalls_seen = stall_reqs;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        erode_take(cmd, pix);
        @(negedge i_clk);
    endtask

    // Waits until every queued result has arrived and the pipeline has emptied.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (eroded_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RADIUS: begin
                cfg_radius = val[RAD_W-1:0];
                clear_positions();
            end
            CFG_WIDTH: begin
                cfg_width = val;
                clear_positions();
            end
            CFG_HEIGHT: begin
                cfg_height = val;
                clear_positions();
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int black_pct, input bit noisy, output bit cut);
        int total, tail, stop, i;
        total = eff_width() * eff_height();
        tail = eff_radius() * eff_width() + eff_radius();
        stop = total;
        cut = 1'b0;
        if (noisy && $urandom_range(99) < 4) begin
            stop = $urandom_range(total - 1);
            cut = 1'b1;
        end
        for (i = 0; i < stop; i++) begin
            if (noisy && $urandom_range(99) < 5) push_item(CMD_FLUSH, PIX_W'($urandom));
            push_item(CMD_PIXEL, rand_pixel(black_pct));
        end
        if (cut) return;
        for (i = 0; i < tail; i++) begin
            if (noisy && $urandom_range(99) < 25) push_item(CMD_PIXEL, rand_pixel(50));
            else push_item(CMD_FLUSH, PIX_W'($urandom));
        end
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // Reset radius of five on a one-pixel-wide column: a black pixel six rows down
    // leaves row 0 white and blackens row 1.
    task automatic test_reset_radius();
        int i;
        write_reg(CFG_WIDTH, DIM_W'(1));
        for (i = 0; i < 12; i++)
            push_item(CMD_PIXEL, (i == 6) ? PIX_BLACK : ((i == 0) ? 8'd1 : PIX_WHITE));
    endtask

    task automatic test_single_pixel();
        write_reg(CFG_RADIUS, DIM_W'(0));
        write_reg(CFG_HEIGHT, DIM_W'(1));
        push_item(CMD_FLUSH, PIX_WHITE);
        push_item(CMD_PIXEL, PIX_BLACK);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_PIXEL, 8'd1);
        push_item(CMD_PIXEL, 8'd128);
    endtask

    // A 3x3 frame with one black corner pixel, an unused register index written
    // mid-frame, an early flush, and a pixel arriving during the drain.
    task automatic test_edges_and_drain();
        write_reg(CFG_RADIUS, DIM_W'(1));
        write_reg(CFG_WIDTH, DIM_W'(3));
        write_reg(CFG_HEIGHT, DIM_W'(3));
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_PIXEL, 8'd64);
        push_item(CMD_PIXEL, PIX_BLACK);
        write_reg(CFG_NONE, 11'h555);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_PIXEL, 8'd2);
        push_item(CMD_FLUSH, PIX_BLACK);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_PIXEL, 8'd127);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_FLUSH, PIX_WHITE);
        push_item(CMD_PIXEL, PIX_BLACK);
        push_item(CMD_PIXEL, PIX_WHITE);
        push_item(CMD_FLUSH, PIX_BLACK);
    endtask

    task automatic test_random_frames(input int item_goal);
        int sent, rad, black_pct;
        bit cut;
        sent = 0;
        cut = 1'b0;
        while (sent < item_goal) begin
            if (cut || $urandom_range(99) < 70) begin
                if (cut || $urandom_range(1)) begin
                    rad = ($urandom_range(9) == 9) ? $urandom_range(9, 15) : $urandom_range(8);
                    write_reg(CFG_RADIUS, {7'($urandom_range(127)), 4'(rad)});
                end
                if ($urandom_range(1))
                    write_reg(CFG_WIDTH, ($urandom_range(19) == 0) ?
                              DIM_W'(0) : DIM_W'($urandom_range(1, 24)));
                if ($urandom_range(1))
                    write_reg(CFG_HEIGHT, ($urandom_range(19) == 0) ?
                              DIM_W'(0) : DIM_W'($urandom_range(1, 16)));
            end
            case ($urandom_range(3))
                0: black_pct = 2;
                1: black_pct = 8;
                2: black_pct = 25;
                default: black_pct = 60;
            endcase
            sent += eff_width() * eff_height() + eff_radius() * eff_width() + eff_radius();
            send_frame(black_pct, 1'b1, cut);
        end
    endtask

    task automatic test_backpressure();
        bit cut;
        write_reg(CFG_RADIUS, DIM_W'(1));
        write_reg(CFG_WIDTH, DIM_W'(16));
        write_reg(CFG_HEIGHT, DIM_W'(8));
        stall_reqs++;
        send_frame(10, 1'b0, cut);
    endtask

    // The widest frame is abandoned after its first pixels by a register write.
    task automatic test_size_extremes();
        bit cut;
        int i;
        write_reg(CFG_RADIUS, 11'h7FF);
        write_reg(CFG_WIDTH, DIM_W'(0));
        write_reg(CFG_HEIGHT, DIM_W'(24));
        send_frame(3, 1'b0, cut);
        write_reg(CFG_RADIUS, DIM_W'(0));
        write_reg(CFG_WIDTH, 11'h7FF);
        write_reg(CFG_HEIGHT, DIM_W'(0));
        for (i = 0; i < 48; i++)
            push_item(CMD_PIXEL, rand_pixel(10));
        write_reg(CFG_HEIGHT, DIM_W'(1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_PIXEL;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RADIUS;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        stall_reqs = 0;
        clear_positions();
        set_idling(27, 47);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_radius();
        test_single_pixel();
        test_edges_and_drain();
        test_random_frames(200);
        set_idling(47, 27);
        test_random_frames(200);
        test_backpressure();
        set_idling(0, 0);
        test_random_frames(200);
        test_size_extremes();

        settle();
        repeat (16) @(negedge i_clk);
        if (errors == 0 && eroded_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== binary_square_erosion.f =====
+incdir+design
design/bse_pkg.sv
design/bse_out_fifo.sv
design/binary_square_erosion.sv
verif/testbench.sv
